/* design/dhm_pkg.sv */
// Shared types and constants for the double handshake master.
// Holds the channel state encoding, the per-channel memory entry and the item layout.
// Depends on nothing.
package dhm_pkg;

    localparam int CHAN_W = 4;
    localparam int CMD_W  = 32;
    localparam int TIME_W = 64;

    typedef enum logic [2:0] {
        ST_READY   = 3'd0,
        ST_SENDING = 3'd1,
        ST_CLEAR   = 3'd2,
        ST_DONE    = 3'd3,
        ST_ERROR   = 3'd4
    } chan_state_t;

    typedef struct packed {
        chan_state_t        state;
        logic [CMD_W-1:0]   prev_command;
        logic [CMD_W-1:0]   held_command;
        logic [TIME_W-1:0]  start_time;
    } chan_entry_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [CMD_W-1:0]   ack;
        logic [CMD_W-1:0]   clear;
        logic [TIME_W-1:0]  now;
    } item_t;

    localparam chan_entry_t ENTRY_RESET = '{
        state:        ST_READY,
        prev_command: '0,
        held_command: '0,
        start_time:   '0
    };

endpackage

/* design/double_handshake_master.sv */
// Master side of a double handshake for up to CHANNELS channels, one channel per item.
// The block takes one item every cycle while in_stall is low and registers each result:
// the accepting edge reads the channel's entry from the state memory; when stage 1 advances,
// it updates, writes the entry back and loads the output register. An item for the
// channel the previous item writes back takes the new entry through a forwarding register.
// After reset every channel reads as READY with all fields zero; no clearing pass is needed.
// Channels not below CHANNELS change no state and report ERROR with command zero.
module double_handshake_master #(
    parameter int CHANNELS  = 16,
    parameter int CMD_BYTES = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [dhm_pkg::TIME_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [dhm_pkg::CHAN_W-1:0] channel,
    input  logic [dhm_pkg::CMD_W-1:0]  command_in,
    input  logic [dhm_pkg::CMD_W-1:0]  ack_in,
    input  logic [dhm_pkg::CMD_W-1:0]  clear_in,
    input  logic [dhm_pkg::TIME_W-1:0] time_now,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [dhm_pkg::CHAN_W-1:0] channel_out,
    output logic [dhm_pkg::CMD_W-1:0]  command_out,
    output logic [2:0]                 state_code
);

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [dhm_pkg::CMD_W-1:0] CMD_MASK = (CMD_BYTES >= 4) ? '1 :
        dhm_pkg::CMD_W'((64'd1 << (8 * CMD_BYTES)) - 64'd1);

    logic [dhm_pkg::TIME_W-1:0] timeout_reg;

    logic                       s1_valid_reg;
    logic [dhm_pkg::CHAN_W-1:0] s1_channel_reg;
    logic                       s1_in_range_reg;
    dhm_pkg::item_t             s1_item_reg;
    logic                       fwd_hit_reg;
    dhm_pkg::chan_entry_t       fwd_data_reg;

    logic                       out_valid_reg;
    logic [dhm_pkg::CHAN_W-1:0] channel_out_reg;
    logic [dhm_pkg::CMD_W-1:0]  command_out_reg;
    dhm_pkg::chan_state_t       state_out_reg;

    logic                       accept;
    logic                       s1_adv;
    logic                       wr_en;
    logic                       in_range;
    logic                       fwd_hit_next;
    dhm_pkg::item_t             item_in;
    dhm_pkg::chan_entry_t       mem_rd_data;
    dhm_pkg::chan_entry_t       cur_entry;
    dhm_pkg::chan_entry_t       upd_entry;
    logic [dhm_pkg::CMD_W-1:0]  upd_command;
    dhm_pkg::chan_state_t       upd_state;

    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;
    assign wr_en    = s1_valid_reg && s1_adv && s1_in_range_reg;
    assign in_range = 32'(channel) < 32'(CHANNELS);

    assign item_in.command = command_in & CMD_MASK;
    assign item_in.ack     = ack_in & CMD_MASK;
    assign item_in.clear   = clear_in;
    assign item_in.now     = time_now;

    assign fwd_hit_next = wr_en && (s1_channel_reg == channel);
    assign cur_entry    = fwd_hit_reg ? fwd_data_reg : mem_rd_data;

    dhm_state_mem #(
        .DEPTH  (CHANNELS),
        .ADDR_W (ADDR_W)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (ADDR_W'(channel)),
        .rd_data (mem_rd_data),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(s1_channel_reg)),
        .wr_data (upd_entry)
    );

    dhm_update u_update (
        .cur           (cur_entry),
        .item          (s1_item_reg),
        .timeout_ticks (timeout_reg),
        .in_range      (s1_in_range_reg),
        .nxt           (upd_entry),
        .command_res   (upd_command),
        .state_res     (upd_state)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= '1;
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= fwd_hit_next;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_channel_reg  <= channel;
            s1_in_range_reg <= in_range;
            s1_item_reg     <= item_in;
            fwd_data_reg    <= upd_entry;
        end
        if (s1_adv && s1_valid_reg)
        begin
            channel_out_reg <= s1_channel_reg;
            command_out_reg <= upd_command;
            state_out_reg   <= upd_state;
        end
    end

    assign out_valid   = out_valid_reg;
    assign channel_out = channel_out_reg;
    assign command_out = command_out_reg;
    assign state_code  = state_out_reg;

    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled while the pipeline has room");

    a_done_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (state_code == dhm_pkg::ST_DONE)) |-> (command_out == '0))
        else $error("DONE result with a presented command");

    a_active_command: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((state_code == dhm_pkg::ST_SENDING) ||
                       (state_code == dhm_pkg::ST_CLEAR))) |-> (command_out != '0))
        else $error("SENDING or CLEAR result without a presented command");

endmodule

/* design/dhm_state_mem.sv */
// Per-channel state memory with a registered read.
// Entries that were never written since reset read as the reset entry.
// Depends on dhm_pkg.
module dhm_state_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output dhm_pkg::chan_entry_t rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  dhm_pkg::chan_entry_t wr_data
);

    dhm_pkg::chan_entry_t mem [DEPTH];
    logic [DEPTH-1:0]     written_reg;
    dhm_pkg::chan_entry_t rd_data_reg;
    logic                 rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? rd_data_reg : dhm_pkg::ENTRY_RESET;

endmodule

/* design/dhm_update.sv */
// Handshake update for one channel: next state and stored fields from one item.
// Pure combinational logic between the memory read and the write-back.
// Depends on dhm_pkg.
module dhm_update (
    input  dhm_pkg::chan_entry_t        cur,
    input  dhm_pkg::item_t              item,
    input  logic [dhm_pkg::TIME_W-1:0]  timeout_ticks,
    input  logic                        in_range,
    output dhm_pkg::chan_entry_t        nxt,
    output logic [dhm_pkg::CMD_W-1:0]   command_res,
    output dhm_pkg::chan_state_t        state_res
);

    logic [dhm_pkg::TIME_W-1:0] elapsed;
    logic                       timed_out;
    logic                       cmd_change;
    logic                       cmd_fall;
    dhm_pkg::chan_state_t       state_next;

    assign elapsed    = item.now - cur.start_time;
    assign timed_out  = elapsed > timeout_ticks;
    assign cmd_change = (item.command != cur.prev_command) && (item.command != '0);
    assign cmd_fall   = (cur.prev_command != '0) && (item.command == '0);

    always_comb
    begin
        state_next = cur.state;
        case (cur.state)
            dhm_pkg::ST_ERROR:
            begin
                if (cmd_fall)
                begin
                    state_next = dhm_pkg::ST_READY;
                end
            end
            dhm_pkg::ST_READY:
            begin
                if (item.ack != '0)
                begin
                    state_next = dhm_pkg::ST_ERROR;
                end
                else if (cmd_change)
                begin
                    state_next = dhm_pkg::ST_SENDING;
                end
            end
            dhm_pkg::ST_SENDING:
            begin
                if (timed_out)
                begin
                    state_next = dhm_pkg::ST_ERROR;
                end
                else if (item.ack == cur.prev_command)
                begin
                    state_next = dhm_pkg::ST_CLEAR;
                end
                else if (item.ack != '0)
                begin
                    state_next = dhm_pkg::ST_ERROR;
                end
            end
            dhm_pkg::ST_CLEAR:
            begin
                if (timed_out || (item.ack != cur.prev_command))
                begin
                    state_next = dhm_pkg::ST_ERROR;
                end
                else if (item.clear == '0)
                begin
                    state_next = dhm_pkg::ST_DONE;
                end
            end
            dhm_pkg::ST_DONE:
            begin
                if (timed_out)
                begin
                    state_next = dhm_pkg::ST_ERROR;
                end
                else if (item.ack == cur.held_command)
                begin
                    state_next = dhm_pkg::ST_READY;
                end
                else if (item.ack != cur.prev_command)
                begin
                    state_next = dhm_pkg::ST_ERROR;
                end
            end
            default:
            begin
                state_next = dhm_pkg::ST_ERROR;
            end
        endcase
    end

    always_comb
    begin
        nxt       = cur;
        nxt.state = state_next;
        case (cur.state)
            dhm_pkg::ST_ERROR:
            begin
                nxt.prev_command = item.command;
            end
            dhm_pkg::ST_READY:
            begin
                if (item.ack == '0)
                begin
                    nxt.prev_command = item.command;
                    if (cmd_change)
                    begin
                        nxt.held_command = item.command;
                        nxt.start_time   = item.now;
                    end
                end
            end
            dhm_pkg::ST_CLEAR:
            begin
                if (!timed_out && (item.ack == cur.prev_command) && (item.clear == '0))
                begin
                    nxt.held_command = '0;
                end
            end
            default:
            begin
                nxt = cur;
                nxt.state = state_next;
            end
        endcase
    end

    assign command_res = in_range ? nxt.held_command : '0;
    assign state_res   = in_range ? state_next : dhm_pkg::ST_ERROR;

endmodule
